// File: rtl/core/prm_pkg.sv
// Shared types and register indexes for the power rail protection monitor.
package prm_pkg;

	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned CNT_W   = 8;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	typedef enum logic [2:0] {
		REG_ADAPTOR_OVER    = 3'd0,
		REG_ADAPTOR_UNDER   = 3'd1,
		REG_ADAPTOR_PRESENT = 3'd2,
		REG_BATTERY_OVER    = 3'd3,
		REG_BATTERY_UNDER   = 3'd4,
		REG_BATTERY_FULL    = 3'd5,
		REG_FAN_OVER        = 3'd6,
		REG_FAN_UNDER       = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ADP_NORMAL  = 2'd0,
		ADP_OVER    = 2'd1,
		ADP_UNDER   = 2'd2,
		ADP_SETTLE  = 2'd3
	} adp_code_t;

	typedef enum logic [1:0] {
		BAT_NORMAL = 2'd0,
		BAT_OVER   = 2'd1,
		BAT_UNDER  = 2'd2,
		BAT_FULL   = 2'd3
	} bat_code_t;

	typedef struct packed {
		level_t adaptor_mv;
		level_t battery_mv;
		level_t fan_ma;
	} sample_t;

	typedef struct packed {
		logic [1:0] adaptor_code;
		logic [1:0] battery_code;
		logic       fan_fault;
	} status_t;

	typedef struct packed {
		level_t adaptor_over_level;
		level_t adaptor_under_level;
		level_t adaptor_present_level;
		level_t battery_over_level;
		level_t battery_under_level;
		level_t battery_full_level;
		level_t fan_over_level;
		level_t fan_under_level;
	} cfg_t;

	typedef struct packed {
		adp_code_t adaptor_status;
		cnt_t      adaptor_over_count;
		cnt_t      adaptor_under_count;
		bat_code_t battery_status;
		cnt_t      battery_over_count;
		cnt_t      battery_under_count;
		logic      fan_status;
		cnt_t      fan_over_count;
		cnt_t      fan_resume_count;
	} rail_state_t;

	localparam cfg_t CFG_RESET = '{
		adaptor_over_level:    16'd26000,
		adaptor_under_level:   16'd18000,
		adaptor_present_level: 16'd16500,
		battery_over_level:    16'd16800,
		battery_under_level:   16'd12000,
		battery_full_level:    16'd16500,
		fan_over_level:        16'd2000,
		fan_under_level:       16'd50
	};

	function automatic cnt_t sat_inc(input cnt_t c);
		return (c == '1) ? c : cnt_t'(c + 1'b1);
	endfunction

endpackage

// File: rtl/core/prm_cfg_regs.sv
// Threshold register file with a plain write port.
module prm_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  prm_pkg::reg_idx_t     cfg_index,
	input  prm_pkg::level_t       cfg_data,
	output prm_pkg::cfg_t         cfg
);
	import prm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ADAPTOR_OVER:    cfg_q.adaptor_over_level    <= cfg_data;
				REG_ADAPTOR_UNDER:   cfg_q.adaptor_under_level   <= cfg_data;
				REG_ADAPTOR_PRESENT: cfg_q.adaptor_present_level <= cfg_data;
				REG_BATTERY_OVER:    cfg_q.battery_over_level    <= cfg_data;
				REG_BATTERY_UNDER:   cfg_q.battery_under_level   <= cfg_data;
				REG_BATTERY_FULL:    cfg_q.battery_full_level    <= cfg_data;
				REG_FAN_OVER:        cfg_q.fan_over_level        <= cfg_data;
				REG_FAN_UNDER:       cfg_q.fan_under_level       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/prm_classify.sv
// Next-state logic: debounce counters and status codes for all three rails.
module prm_classify #(
	parameter int unsigned DEBOUNCE_COUNT = 10
) (
	input  prm_pkg::sample_t     sample,
	input  prm_pkg::cfg_t        cfg,
	input  prm_pkg::rail_state_t cur,
	output prm_pkg::rail_state_t nxt
);
	import prm_pkg::*;

	localparam cnt_t D1 = cnt_t'(DEBOUNCE_COUNT);
	localparam cnt_t D2 = cnt_t'(2 * DEBOUNCE_COUNT);
	localparam cnt_t D5 = cnt_t'(5 * DEBOUNCE_COUNT);

	cnt_t a_over_inc, a_under_inc, b_over_inc, b_under_inc, f_over_inc, f_resume_inc;
	level_t av, bv, fv;

	assign av = sample.adaptor_mv;
	assign bv = sample.battery_mv;
	assign fv = sample.fan_ma;

	assign a_over_inc   = sat_inc(cur.adaptor_over_count);
	assign a_under_inc  = sat_inc(cur.adaptor_under_count);
	assign b_over_inc   = sat_inc(cur.battery_over_count);
	assign b_under_inc  = sat_inc(cur.battery_under_count);
	assign f_over_inc   = sat_inc(cur.fan_over_count);
	assign f_resume_inc = sat_inc(cur.fan_resume_count);

	always_comb begin
		nxt = cur;

		// adaptor: branch order matters, equality with the under level falls to normal
		if (av >= cfg.adaptor_over_level) begin
			nxt.adaptor_over_count = a_over_inc;
			if (a_over_inc >= D1) begin
				nxt.adaptor_status      = ADP_OVER;
				nxt.adaptor_under_count = '0;
			end
		end else if (av > cfg.adaptor_present_level && av < cfg.adaptor_under_level) begin
			nxt.adaptor_under_count = a_under_inc;
			if (a_under_inc >= D1) begin
				nxt.adaptor_status     = ADP_UNDER;
				nxt.adaptor_over_count = '0;
			end
		end else if (av > cfg.adaptor_under_level && av < cfg.adaptor_over_level) begin
			if (cur.adaptor_over_count >= D2) begin
				nxt.adaptor_under_count = '0;
			end else if (cur.adaptor_over_count >= D1) begin
				nxt.adaptor_status     = ADP_SETTLE;
				nxt.adaptor_over_count = a_over_inc;
			end else begin
				nxt.adaptor_over_count = a_over_inc;
			end
		end else begin
			nxt.adaptor_status      = ADP_NORMAL;
			nxt.adaptor_over_count  = '0;
			nxt.adaptor_under_count = '0;
		end

		if (bv >= cfg.battery_over_level) begin
			nxt.battery_over_count = b_over_inc;
			if (b_over_inc >= D1) begin
				nxt.battery_status      = BAT_OVER;
				nxt.battery_under_count = '0;
			end
		end else if (bv < cfg.battery_under_level) begin
			nxt.battery_under_count = b_under_inc;
			if (b_under_inc >= D1)
				nxt.battery_status = BAT_UNDER;
		end else if (bv >= cfg.battery_full_level) begin
			nxt.battery_over_count = b_over_inc;
			if (b_over_inc >= D1) begin
				nxt.battery_status      = BAT_FULL;
				nxt.battery_over_count  = '0;
				nxt.battery_under_count = '0;
			end
		end else begin
			nxt.battery_status      = BAT_NORMAL;
			nxt.battery_over_count  = '0;
			nxt.battery_under_count = '0;
		end

		// fan: samples below the under level leave everything as is
		if (fv >= cfg.fan_over_level) begin
			nxt.fan_over_count   = f_over_inc;
			nxt.fan_resume_count = '0;
			if (f_over_inc >= D1)
				nxt.fan_status = 1'b1;
		end else if (fv >= cfg.fan_under_level) begin
			nxt.fan_resume_count = f_resume_inc;
			if (f_resume_inc >= D5) begin
				nxt.fan_status       = 1'b0;
				nxt.fan_over_count   = '0;
				nxt.fan_resume_count = '0;
			end
		end
	end

endmodule

// File: rtl/core/power_rail_protection_monitor_top.sv
// Top level of the power rail protection monitor.
// One sample set (adaptor mV, battery mV, fan mA) goes in per request and one status
// request comes out for each, in order. A sample is registered on acceptance and its
// rail state update and status codes are registered into the output register once that
// register is free or being drained, and a new one is accepted every cycle;
// the only limit on rate is the output side draining. The input register and the
// output register decouple the two channels, so one sample is taken while a status
// waits. Thresholds reset to their documented defaults and should be written only
// while no sample is in flight. DEBOUNCE_COUNT (1 to 50) sets the number of
// consecutive samples that confirm a condition; counters saturate at 255.
module power_rail_protection_monitor_top #(
	parameter int unsigned DEBOUNCE_COUNT = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  prm_pkg::sample_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output prm_pkg::status_t    out_data,
	input  logic                cfg_wr_en,
	input  prm_pkg::reg_idx_t   cfg_index,
	input  prm_pkg::level_t     cfg_data
);
	import prm_pkg::*;

	cfg_t        cfg;
	sample_t     sample_s1;
	logic        valid_s1;
	rail_state_t state_q, state_nxt;
	status_t     out_data_q;
	logic        out_valid_q;
	logic        advance;

	prm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	prm_classify #(
		.DEBOUNCE_COUNT (DEBOUNCE_COUNT)
	) u_classify (
		.sample (sample_s1),
		.cfg    (cfg),
		.cur    (state_q),
		.nxt    (state_nxt)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= in_data;
	end

	// commit rail state only when the request moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.adaptor_code <= state_nxt.adaptor_status;
			out_data_q.battery_code <= state_nxt.battery_status;
			out_data_q.fan_fault    <= state_nxt.fan_status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// File: rtl/core/prm_checker.sv
// Port-level checks for the power rail protection monitor, bound to the top level.
module prm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input prm_pkg::status_t  out_data
);
	import prm_pkg::*;

	// a stalled status request holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("status request dropped or changed while stalled");

	// with the output side empty the input side never stalls
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	// a status request appears only in answer to an accepted sample
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("status request without an accepted sample");

endmodule

bind power_rail_protection_monitor_top prm_checker u_prm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: test/tb_power_rail_protection_monitor_top.sv
// Self-checking testbench for the power rail protection monitor top level.
`timescale 1ns / 1ps

module tb_power_rail_protection_monitor_top;
	import prm_pkg::*;

	localparam int unsigned DEB            = 10;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam int          HOLD_OFF_LEN   = 300;

	// Tracks thresholds and debounce state, and queues the status each sample should give.
	class rail_scoreboard;
		cfg_t        levels;
		rail_state_t st;
		status_t     status_q[$];
		int          errors;

		function new();
			levels = CFG_RESET;
			st = '0;
			errors = 0;
		endfunction

		function cnt_t sat_up(cnt_t c);
			return (c == 8'hFF) ? c : cnt_t'(c + 8'd1);
		endfunction

		function void set_level(reg_idx_t idx, level_t v);
			case (idx)
				REG_ADAPTOR_OVER:    levels.adaptor_over_level = v;
				REG_ADAPTOR_UNDER:   levels.adaptor_under_level = v;
				REG_ADAPTOR_PRESENT: levels.adaptor_present_level = v;
				REG_BATTERY_OVER:    levels.battery_over_level = v;
				REG_BATTERY_UNDER:   levels.battery_under_level = v;
				REG_BATTERY_FULL:    levels.battery_full_level = v;
				REG_FAN_OVER:        levels.fan_over_level = v;
				REG_FAN_UNDER:       levels.fan_under_level = v;
				default: ;
			endcase
		endfunction

		function void note_sample(sample_t s);
			status_t want;
			// adaptor: branch order matters, equal-to-under falls to the clear branch
			if (s.adaptor_mv >= levels.adaptor_over_level) begin
				st.adaptor_over_count = sat_up(st.adaptor_over_count);
				if (st.adaptor_over_count >= DEB) begin
					st.adaptor_status = ADP_OVER;
					st.adaptor_under_count = '0;
				end
			end else if (s.adaptor_mv > levels.adaptor_present_level &&
					s.adaptor_mv < levels.adaptor_under_level) begin
				st.adaptor_under_count = sat_up(st.adaptor_under_count);
				if (st.adaptor_under_count >= DEB) begin
					st.adaptor_status = ADP_UNDER;
					st.adaptor_over_count = '0;
				end
			end else if (s.adaptor_mv > levels.adaptor_under_level &&
					s.adaptor_mv < levels.adaptor_over_level) begin
				if (st.adaptor_over_count >= 2 * DEB) begin
					st.adaptor_under_count = '0;
				end else if (st.adaptor_over_count >= DEB) begin
					st.adaptor_status = ADP_SETTLE;
					st.adaptor_over_count = sat_up(st.adaptor_over_count);
				end else begin
					st.adaptor_over_count = sat_up(st.adaptor_over_count);
				end
			end else begin
				st.adaptor_status = ADP_NORMAL;
				st.adaptor_over_count = '0;
				st.adaptor_under_count = '0;
			end

			if (s.battery_mv >= levels.battery_over_level) begin
				st.battery_over_count = sat_up(st.battery_over_count);
				if (st.battery_over_count >= DEB) begin
					st.battery_status = BAT_OVER;
					st.battery_under_count = '0;
				end
			end else if (s.battery_mv < levels.battery_under_level) begin
				st.battery_under_count = sat_up(st.battery_under_count);
				if (st.battery_under_count >= DEB)
					st.battery_status = BAT_UNDER;
			end else if (s.battery_mv >= levels.battery_full_level) begin
				st.battery_over_count = sat_up(st.battery_over_count);
				if (st.battery_over_count >= DEB) begin
					st.battery_status = BAT_FULL;
					st.battery_over_count = '0;
					st.battery_under_count = '0;
				end
			end else begin
				st.battery_status = BAT_NORMAL;
				st.battery_over_count = '0;
				st.battery_under_count = '0;
			end

			// fan: samples below the under level leave everything alone
			if (s.fan_ma >= levels.fan_over_level) begin
				st.fan_over_count = sat_up(st.fan_over_count);
				if (st.fan_over_count >= DEB)
					st.fan_status = 1'b1;
				st.fan_resume_count = '0;
			end else if (s.fan_ma >= levels.fan_under_level) begin
				st.fan_resume_count = sat_up(st.fan_resume_count);
				if (st.fan_resume_count >= 5 * DEB) begin
					st.fan_status = 1'b0;
					st.fan_over_count = '0;
					st.fan_resume_count = '0;
				end
			end

			want.adaptor_code = st.adaptor_status;
			want.battery_code = st.battery_status;
			want.fan_fault = st.fan_status;
			status_q.push_back(want);
		endfunction

		task report(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_status(status_t got);
			status_t want;
			if (status_q.size() == 0) begin
				report($sformatf("status %h with no sample pending", got));
				return;
			end
			want = status_q.pop_front();
			if (got.adaptor_code !== want.adaptor_code)
				report($sformatf("adaptor_code %0d, want %0d", got.adaptor_code,
					want.adaptor_code));
			if (got.battery_code !== want.battery_code)
				report($sformatf("battery_code %0d, want %0d", got.battery_code,
					want.battery_code));
			if (got.fan_fault !== want.fan_fault)
				report($sformatf("fan_fault %0d, want %0d", got.fan_fault, want.fan_fault));
		endtask

		function int pending();
			return status_q.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	sample_t  in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	status_t  out_data;
	logic     cfg_wr_en = 1'b0;
	reg_idx_t cfg_index = REG_ADAPTOR_OVER;
	level_t   cfg_data = '0;

	rail_scoreboard sb = new();

	int tx_idle_pct = 38;
	int rx_idle_pct = 38;
	bit hold_off_req = 1'b0;
	int stall_cycles = 0;
	int adp_region = 0, adp_left = 0;
	int bat_region = 0, bat_left = 0;
	int fan_region = 0, fan_left = 0;

	power_rail_protection_monitor_top #(.DEBOUNCE_COUNT(DEB)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random back-pressure, plus one long hold-off on demand.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_LEN) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_status(out_data);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_sample(input sample_t s);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(s);
		@(negedge clk);
	endtask

	task automatic send_set(input level_t a, input level_t b, input level_t f, input int n);
		sample_t s;
		s.adaptor_mv = a;
		s.battery_mv = b;
		s.fan_ma = f;
		repeat (n) send_sample(s);
	endtask

	// Drop valid and wait until every queued status has come back.
	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_level(input reg_idx_t idx, input level_t v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.set_level(idx, v);
		@(negedge clk);
	endtask

	task automatic load_levels(input cfg_t c);
		write_level(REG_ADAPTOR_OVER, c.adaptor_over_level);
		write_level(REG_ADAPTOR_UNDER, c.adaptor_under_level);
		write_level(REG_ADAPTOR_PRESENT, c.adaptor_present_level);
		write_level(REG_BATTERY_OVER, c.battery_over_level);
		write_level(REG_BATTERY_UNDER, c.battery_under_level);
		write_level(REG_BATTERY_FULL, c.battery_full_level);
		write_level(REG_FAN_OVER, c.fan_over_level);
		write_level(REG_FAN_UNDER, c.fan_under_level);
		cfg_wr_en <= 1'b0;
	endtask

	// Thresholds in their intended order, windows up to span wide (fan up to twice span).
	function automatic cfg_t ordered_levels(input int span);
		cfg_t c;
		int lo, mid;
		lo = $urandom_range(30000);
		mid = lo + $urandom_range(span, 1);
		c.adaptor_present_level = level_t'(lo);
		c.adaptor_under_level = level_t'(mid);
		c.adaptor_over_level = level_t'(mid + $urandom_range(span, 1));
		lo = $urandom_range(30000);
		mid = lo + $urandom_range(span, 1);
		c.battery_under_level = level_t'(lo);
		c.battery_full_level = level_t'(mid);
		c.battery_over_level = level_t'(mid + $urandom_range(span, 1));
		lo = $urandom_range(30000);
		c.fan_under_level = level_t'(lo);
		c.fan_over_level = level_t'(lo + $urandom_range(2 * span, 1));
		return c;
	endfunction

	function automatic cfg_t scrambled_levels();
		cfg_t c;
		c.adaptor_over_level = level_t'($urandom);
		c.adaptor_under_level = level_t'($urandom);
		c.adaptor_present_level = level_t'($urandom);
		c.battery_over_level = level_t'($urandom);
		c.battery_under_level = level_t'($urandom);
		c.battery_full_level = level_t'($urandom);
		c.fan_over_level = level_t'($urandom);
		c.fan_under_level = level_t'($urandom);
		return c;
	endfunction

	// Value in [lo, hi]; an empty window gives any value.
	function automatic level_t pick(input int lo, input int hi);
		if (lo > hi)
			return level_t'($urandom);
		return level_t'($urandom_range(hi, lo));
	endfunction

	// Mostly debounce-scale runs, now and then long enough to saturate a counter.
	function automatic int run_len();
		if ($urandom_range(99) < 8)
			return $urandom_range(320, 200);
		return $urandom_range(70, 1);
	endfunction

	function automatic level_t adaptor_value(input int r);
		int o, u, p;
		o = sb.levels.adaptor_over_level;
		u = sb.levels.adaptor_under_level;
		p = sb.levels.adaptor_present_level;
		case (r)
			0: return pick(o, 65535);
			1: return pick(p + 1, u - 1);
			2: return pick(u + 1, o - 1);
			3: return level_t'(u);
			4: return pick(0, p);
			5: return level_t'(o);
			default: return level_t'(p);
		endcase
	endfunction

	function automatic level_t battery_value(input int r);
		int o, u, f;
		o = sb.levels.battery_over_level;
		u = sb.levels.battery_under_level;
		f = sb.levels.battery_full_level;
		case (r)
			0: return pick(o, 65535);
			1: return pick(0, u - 1);
			2: return pick(f, o - 1);
			3: return pick(u, f - 1);
			4: return level_t'(f);
			default: return level_t'(u);
		endcase
	endfunction

	function automatic level_t fan_value(input int r);
		int o, u;
		o = sb.levels.fan_over_level;
		u = sb.levels.fan_under_level;
		case (r)
			0: return pick(o, 65535);
			1: return pick(0, u - 1);
			2: return pick(u, o - 1);
			3: return level_t'(o);
			default: return level_t'(u);
		endcase
	endfunction

	task automatic run_random(input int n);
		sample_t s;
		repeat (n) begin
			if (adp_left == 0) begin
				adp_region = $urandom_range(6);
				adp_left = run_len();
			end
			if (bat_left == 0) begin
				bat_region = $urandom_range(5);
				bat_left = run_len();
			end
			if (fan_left == 0) begin
				fan_region = $urandom_range(4);
				fan_left = run_len();
			end
			adp_left--;
			bat_left--;
			fan_left--;
			if ($urandom_range(99) < 15) begin
				s.adaptor_mv = level_t'($urandom);
				s.battery_mv = level_t'($urandom);
				s.fan_ma = level_t'($urandom);
			end else begin
				s.adaptor_mv = adaptor_value(adp_region);
				s.battery_mv = battery_value(bat_region);
				s.fan_ma = fan_value(fan_region);
			end
			send_sample(s);
		end
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset thresholds: field extremes, values on and next to every threshold
		send_set(16'h0000, 16'h0000, 16'h0000, 1);
		send_set(16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
		send_set(16'd26000, 16'd16800, 16'd2000, 1);
		send_set(16'd25999, 16'd16799, 16'd1999, 1);
		send_set(16'd18000, 16'd12000, 16'd50, 1);
		send_set(16'd17999, 16'd11999, 16'd49, 1);
		send_set(16'd16500, 16'd16500, 16'd0, 1);
		send_set(16'd16501, 16'd16499, 16'd2001, 1);
		send_set(16'd18001, 16'd12001, 16'd51, 1);
		// confirm over on all rails, then settle window and full charge
		send_set(16'd30000, 16'd20000, 16'd5000, 12);
		send_set(16'd20000, 16'd16600, 16'd100, 3);
		run_random(380);

		// back-pressure burst: sender never idles while the receiver holds off
		settle();
		load_levels(ordered_levels(15000));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_off_req = 1'b1;
		run_random(200);
		tx_idle_pct = 38;
		rx_idle_pct = 38;
		run_random(200);

		settle();
		load_levels('0);
		run_random(150);

		settle();
		load_levels('1);
		run_random(150);

		settle();
		load_levels(scrambled_levels());
		run_random(350);

		settle();
		load_levels(ordered_levels(3));
		run_random(450);

		settle();
		load_levels(CFG_RESET);
		run_random(70);

		settle();
		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/core/prm_pkg.sv
rtl/core/prm_cfg_regs.sv
rtl/core/prm_classify.sv
rtl/core/power_rail_protection_monitor_top.sv
rtl/core/prm_checker.sv
test/tb_power_rail_protection_monitor_top.sv
